[rtl/core/tlpc_pkg.sv]
// ----------------------------------------------------------------------------
// tlpc_pkg: shared types and constants of the tetrakis lattice pixel classifier
// Field widths, register indexes, wedge and glyph codes, and payload structs.
// ----------------------------------------------------------------------------
package tlpc_pkg;

  // Widths of the screen coordinates and of the fixed-point fractions.
  localparam int SCREEN_BITS = 10;
  localparam int FRAC_BITS   = 16;

  // Derived widths.
  localparam int CELL_W   = 4;
  localparam int INV_W    = 14;
  localparam int DIFF_W   = SCREEN_BITS + 1;        // signed position minus origin
  localparam int SCALED_W = DIFF_W + CELL_W + 1;    // signed diff times cell size
  localparam int PROD_W   = SCALED_W + INV_W + 1;   // signed Q.FRAC_BITS position
  localparam int SQ_W     = SCREEN_BITS + 2;        // grid square index
  localparam int DIST_W   = FRAC_BITS + 1;          // 0 .. 1.0 in Q1.FRAC_BITS
  localparam int SIDE_W   = FRAC_BITS + 3;          // signed side distances
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIST_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SIZE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH = 3'd5;

  // Register reset values.
  localparam logic [SCREEN_BITS-1:0] ORIGIN_RST      = '0;
  localparam logic [CELL_W-1:0]      CELL_WIDTH_RST  = 4'd2;
  localparam logic [CELL_W-1:0]      CELL_HEIGHT_RST = 4'd4;
  localparam logic [INV_W-1:0]       INVERSE_RST     = 14'd3641;
  localparam logic [DIST_W-1:0]      BORDER_RST      = 17'd6554;

  // One and one half in Q2.FRAC_BITS, as signed side values.
  localparam logic signed [SIDE_W-1:0] ONE_Q  = SIDE_W'(1) <<< FRAC_BITS;
  localparam logic signed [SIDE_W-1:0] HALF_Q = SIDE_W'(1) <<< (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    WEDGE_N = 2'd0,
    WEDGE_E = 2'd1,
    WEDGE_S = 2'd2,
    WEDGE_W = 2'd3
  } wedge_e;

  typedef enum logic [1:0] {
    GLYPH_SLASH      = 2'd0,
    GLYPH_BACKSLASH  = 2'd1,
    GLYPH_UNDERSCORE = 2'd2,
    GLYPH_BAR        = 2'd3
  } glyph_e;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] screen_col;
    logic [SCREEN_BITS-1:0] screen_row;
  } pix_in_t;

  typedef struct packed {
    logic signed [SQ_W-1:0] square_col;
    logic signed [SQ_W-1:0] square_row;
    wedge_e                 wedge;
    glyph_e                 glyph_code;
    logic [DIST_W-1:0]      edge_distance;
    logic                   on_edge;
  } pix_out_t;

endpackage

[rtl/core/tetrakis_lattice_pixel_classifier.sv]
// ----------------------------------------------------------------------------
// tetrakis_lattice_pixel_classifier: tetrakis square grid pixel classifier
// Maps a screen character position to its grid square, wedge and nearest
// wedge side, with the distance to that side and an on-edge flag.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel transfer takes place at a rising edge with start high and busy
//   low. busy is always low: the pipeline takes one pixel in every cycle.
//   The result appears on out_o with done_o high for exactly one cycle,
//   after the register stages below; results leave in the order the
//   pixels came in. The receiver cannot stall, so no result waits.
//   A pixel passes four register stages: offset times cell size, times
//   the reciprocal square size, wedge and side distances, nearest side.
//   Throughput is one pixel per clock.
//   Configuration registers are written through cfg_we_i, cfg_idx_i and
//   cfg_wdata_i (low bits used); writes to unknown indexes are ignored.
//   Registers should change only while no pixel is in the pipeline.
//   Reset empties the pipeline and loads the register defaults: origin 0,0,
//   cell 2 by 4, square size 18 sub-pixels, border 0.10 of a square.
// ----------------------------------------------------------------------------
module tetrakis_lattice_pixel_classifier import tlpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  pix_in_t               in_i,
  output logic                  done_o,
  output pix_out_t              out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Configuration registers.
  logic [SCREEN_BITS-1:0] origin_x_q, origin_y_q;
  logic [CELL_W-1:0]      cell_width_q, cell_height_q;
  logic [INV_W-1:0]       inverse_q;
  logic [DIST_W-1:0]      border_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    <= ORIGIN_RST;
      origin_y_q    <= ORIGIN_RST;
      cell_width_q  <= CELL_WIDTH_RST;
      cell_height_q <= CELL_HEIGHT_RST;
      inverse_q     <= INVERSE_RST;
      border_q      <= BORDER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORIGIN_X:     origin_x_q    <= cfg_wdata_i[SCREEN_BITS-1:0];
        REG_ORIGIN_Y:     origin_y_q    <= cfg_wdata_i[SCREEN_BITS-1:0];
        REG_CELL_WIDTH:   cell_width_q  <= cfg_wdata_i[CELL_W-1:0];
        REG_CELL_HEIGHT:  cell_height_q <= cfg_wdata_i[CELL_W-1:0];
        REG_INVERSE_SIZE: inverse_q     <= cfg_wdata_i[INV_W-1:0];
        REG_BORDER_WIDTH: border_q      <= cfg_wdata_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the four stages.
  logic       accept;
  logic [2:0] vld_q;
  logic       done_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[1:0], accept};
      done_q <= vld_q[2];
    end
  end

  // Stages one and two: scaled positions of both axes.
  logic signed [PROD_W-1:0] pos_x, pos_y;

  tlpc_axis u_axis_x (
    .clk_i     (clk_i),
    .pos_i     (in_i.screen_col),
    .origin_i  (origin_x_q),
    .cell_i    (cell_width_q),
    .inverse_i (inverse_q),
    .scaled_o  (pos_x)
  );

  tlpc_axis u_axis_y (
    .clk_i     (clk_i),
    .pos_i     (in_i.screen_row),
    .origin_i  (origin_y_q),
    .cell_i    (cell_height_q),
    .inverse_i (inverse_q),
    .scaled_o  (pos_y)
  );

  // Stage three: square index, wedge and the wedge's three side distances.
  logic signed [SIDE_W-1:0] fa, fb, dx, dy, adx, ady;
  logic signed [SIDE_W-1:0] s_nw, s_ab, s_ba, s_ne;
  logic signed [SQ_W-1:0]   col_d, row_d, col_q, row_q;
  wedge_e                   wedge_d, wedge_q;
  logic signed [SIDE_W-1:0] l1_d, l2_d, l3_d, l1_q, l2_q, l3_q;
  glyph_e                   g1_d, g2_d, g3_d, g1_q, g2_q, g3_q;

  always_comb begin
    col_d = pos_x[FRAC_BITS +: SQ_W];
    row_d = pos_y[FRAC_BITS +: SQ_W];
    fa    = $signed({3'b000, pos_x[FRAC_BITS-1:0]});
    fb    = $signed({3'b000, pos_y[FRAC_BITS-1:0]});
    dx    = fa - HALF_Q;
    dy    = fb - HALF_Q;
    adx   = dx[SIDE_W-1] ? -dx : dx;
    ady   = dy[SIDE_W-1] ? -dy : dy;
    if (adx > ady) begin
      wedge_d = (dx > 0) ? WEDGE_E : WEDGE_W;
    end else begin
      wedge_d = (dy > 0) ? WEDGE_S : WEDGE_N;
    end
    // The diagonal sides are shared among the wedges.
    s_nw = ONE_Q - fa - fb;
    s_ab = fa - fb;
    s_ba = fb - fa;
    s_ne = fa + fb - ONE_Q;
    case (wedge_d)
      WEDGE_N: begin
        l1_d = s_nw;           g1_d = GLYPH_SLASH;
        l2_d = s_ab;           g2_d = GLYPH_BACKSLASH;
        l3_d = fb <<< 1;       g3_d = GLYPH_UNDERSCORE;
      end
      WEDGE_E: begin
        l1_d = s_ab;                 g1_d = GLYPH_BACKSLASH;
        l2_d = s_ne;                 g2_d = GLYPH_SLASH;
        l3_d = (ONE_Q - fa) <<< 1;   g3_d = GLYPH_BAR;
      end
      WEDGE_S: begin
        l1_d = s_ba;                 g1_d = GLYPH_BACKSLASH;
        l2_d = s_ne;                 g2_d = GLYPH_SLASH;
        l3_d = (ONE_Q - fb) <<< 1;   g3_d = GLYPH_UNDERSCORE;
      end
      default: begin
        l1_d = s_nw;           g1_d = GLYPH_BACKSLASH;
        l2_d = s_ba;           g2_d = GLYPH_SLASH;
        l3_d = fa <<< 1;       g3_d = GLYPH_BAR;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    row_q   <= row_d;
    wedge_q <= wedge_d;
    l1_q    <= l1_d;
    l2_q    <= l2_d;
    l3_q    <= l3_d;
    g1_q    <= g1_d;
    g2_q    <= g2_d;
    g3_q    <= g3_d;
  end

  // Stage four: nearest side (ties keep the earlier side), clamp, border test.
  logic signed [SIDE_W-1:0] min_dist;
  glyph_e                   min_glyph;
  logic [DIST_W-1:0]        edge_dist;
  pix_out_t                 out_d, out_q;

  always_comb begin
    min_dist  = l1_q;
    min_glyph = g1_q;
    if (l2_q < min_dist) begin
      min_dist  = l2_q;
      min_glyph = g2_q;
    end
    if (l3_q < min_dist) begin
      min_dist  = l3_q;
      min_glyph = g3_q;
    end
    if (min_dist[SIDE_W-1]) begin
      edge_dist = '0;
    end else if (min_dist > ONE_Q) begin
      edge_dist = DIST_W'(ONE_Q);
    end else begin
      edge_dist = min_dist[DIST_W-1:0];
    end
    out_d.square_col    = col_q;
    out_d.square_row    = row_q;
    out_d.wedge         = wedge_q;
    out_d.glyph_code    = min_glyph;
    out_d.edge_distance = edge_dist;
    out_d.on_edge       = (edge_dist < border_q);
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

  // A result comes out only after a matching pixel transfer.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result without a matching pixel transfer");

  // Every pixel transfer yields a result.
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("pixel transfer lost in the pipeline");

  // The distance never exceeds one square.
  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_o.edge_distance <= DIST_W'(ONE_Q)))
    else $error("edge distance beyond one square");

  // North and south wedges have no vertical side; east and west no floor.
  a_glyph_wedge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (((out_o.wedge == WEDGE_N || out_o.wedge == WEDGE_S)
                 && out_o.glyph_code != GLYPH_BAR)
             || ((out_o.wedge == WEDGE_E || out_o.wedge == WEDGE_W)
                 && out_o.glyph_code != GLYPH_UNDERSCORE)))
    else $error("glyph does not belong to the wedge");

endmodule

[rtl/core/tlpc_axis.sv]
// ----------------------------------------------------------------------------
// tlpc_axis: two-stage scaler for one screen axis
// Subtracts the origin, multiplies by the cell size, registers, then
// multiplies by the reciprocal square size into a signed Q.FRAC_BITS value.
// ----------------------------------------------------------------------------
module tlpc_axis import tlpc_pkg::*; (
  input  logic                     clk_i,
  input  logic [SCREEN_BITS-1:0]   pos_i,
  input  logic [SCREEN_BITS-1:0]   origin_i,
  input  logic [CELL_W-1:0]        cell_i,
  input  logic [INV_W-1:0]         inverse_i,
  output logic signed [PROD_W-1:0] scaled_o
);

  logic signed [DIFF_W-1:0]   diff;
  logic signed [SCALED_W-1:0] cell_prod_d, cell_prod_q;
  logic signed [PROD_W-1:0]   scaled_d, scaled_q;

  // First stage: signed offset from the origin times the cell size.
  always_comb begin
    diff        = $signed({1'b0, pos_i}) - $signed({1'b0, origin_i});
    cell_prod_d = SCALED_W'(diff * $signed({1'b0, cell_i}));
  end

  always_ff @(posedge clk_i) begin
    cell_prod_q <= cell_prod_d;
  end

  // Second stage: multiply by the reciprocal of the square size.
  always_comb begin
    scaled_d = PROD_W'(cell_prod_q * $signed({1'b0, inverse_i}));
  end

  always_ff @(posedge clk_i) begin
    scaled_q <= scaled_d;
  end

  assign scaled_o = scaled_q;

endmodule

[tb/tetrakis_lattice_pixel_classifier_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tetrakis_lattice_pixel_classifier_tb: self-checking bench of the classifier
// Sends screen positions under several register settings and compares each
// classified pixel, field by field, with a behavioral prediction of the grid
// square, wedge, nearest side, side distance and on-edge flag.
// ----------------------------------------------------------------------------
module tetrakis_lattice_pixel_classifier_tb;
  import tlpc_pkg::*;

  // Four register stages inside the block; the pause before a register write.
  localparam int PIPE_DEPTH  = 4;
  localparam int DRAIN_PAUSE = PIPE_DEPTH + 2;
  // Cycles without any transfer before the run is declared hung.
  localparam int IDLE_LIMIT  = 500;
  // Indexes that name no register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam longint Q_ONE  = longint'(1) << FRAC_BITS;
  localparam longint Q_HALF = Q_ONE >> 1;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_PIXELS  = 190;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  pix_in_t               in_i        = '0;
  logic                  done_o;
  pix_out_t              out_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Shadow copy of the register file, as the block should hold it.
  logic [SCREEN_BITS-1:0] grid_org_x  = ORIGIN_RST;
  logic [SCREEN_BITS-1:0] grid_org_y  = ORIGIN_RST;
  logic [CELL_W-1:0]      cell_w      = CELL_WIDTH_RST;
  logic [CELL_W-1:0]      cell_h      = CELL_HEIGHT_RST;
  logic [INV_W-1:0]       inv_size    = INVERSE_RST;
  logic [DIST_W-1:0]      border_thr  = BORDER_RST;

  pix_out_t expected_classes[$];
  int       mismatch_count = 0;
  int       results_seen   = 0;
  int       idle_cycles    = 0;
  int       burst_left     = 1;
  bit       gaps_on        = 1'b1;

  tetrakis_lattice_pixel_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predicts the classification of one pixel under the shadow registers.
  function automatic pix_out_t classify_pixel(input pix_in_t px);
    longint   xq, yq, fa, fb, whole_x, whole_y, dx, dy, adx, ady, best;
    longint   side_len[3];
    glyph_e   side_glyph[3];
    glyph_e   best_glyph;
    wedge_e   wdg;
    pix_out_t res;
    xq = (longint'(px.screen_col) - longint'(grid_org_x)) * longint'(cell_w)
         * longint'(inv_size);
    yq = (longint'(px.screen_row) - longint'(grid_org_y)) * longint'(cell_h)
         * longint'(inv_size);
    fa = xq & (Q_ONE - 1);
    fb = yq & (Q_ONE - 1);
    whole_x = (xq - fa) >>> FRAC_BITS;
    whole_y = (yq - fb) >>> FRAC_BITS;

    // Diagonals split the square; a lean tie falls to the north or south wedge.
    dx  = fa - Q_HALF;
    dy  = fb - Q_HALF;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    if (adx > ady) begin
      wdg = (dx > 0) ? WEDGE_E : WEDGE_W;
    end else begin
      wdg = (dy > 0) ? WEDGE_S : WEDGE_N;
    end

    // The three sides of the wedge, in priority order for ties.
    case (wdg)
      WEDGE_N: begin
        side_len[0] = Q_ONE - fa - fb;    side_glyph[0] = GLYPH_SLASH;
        side_len[1] = fa - fb;            side_glyph[1] = GLYPH_BACKSLASH;
        side_len[2] = 2 * fb;             side_glyph[2] = GLYPH_UNDERSCORE;
      end
      WEDGE_E: begin
        side_len[0] = fa - fb;            side_glyph[0] = GLYPH_BACKSLASH;
        side_len[1] = fa + fb - Q_ONE;    side_glyph[1] = GLYPH_SLASH;
        side_len[2] = 2 * (Q_ONE - fa);   side_glyph[2] = GLYPH_BAR;
      end
      WEDGE_S: begin
        side_len[0] = fb - fa;            side_glyph[0] = GLYPH_BACKSLASH;
        side_len[1] = fa + fb - Q_ONE;    side_glyph[1] = GLYPH_SLASH;
        side_len[2] = 2 * (Q_ONE - fb);   side_glyph[2] = GLYPH_UNDERSCORE;
      end
      default: begin
        side_len[0] = Q_ONE - fa - fb;    side_glyph[0] = GLYPH_BACKSLASH;
        side_len[1] = fb - fa;            side_glyph[1] = GLYPH_SLASH;
        side_len[2] = 2 * fa;             side_glyph[2] = GLYPH_BAR;
      end
    endcase
    best       = side_len[0];
    best_glyph = side_glyph[0];
    for (int i = 1; i < 3; i++) begin
      if (side_len[i] < best) begin
        best       = side_len[i];
        best_glyph = side_glyph[i];
      end
    end
    if (best < 0) best = 0;
    if (best > Q_ONE) best = Q_ONE;

    res.square_col    = whole_x[SQ_W-1:0];
    res.square_row    = whole_y[SQ_W-1:0];
    res.wedge         = wdg;
    res.glyph_code    = best_glyph;
    res.edge_distance = best[DIST_W-1:0];
    res.on_edge       = (best < longint'(border_thr));
    return res;
  endfunction

  // Prints one line per failure, up to a cap, and counts every failure.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 30) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  // Result checking and prediction share one process so that a result and a
  // new pixel transfer at the same edge are handled in a fixed order.
  always @(posedge clk_i) begin
    pix_out_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_classes.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no pixel outstanding",
                                    results_seen));
        end else begin
          want = expected_classes.pop_front();
          check_field("square_col", longint'(out_o.square_col), longint'(want.square_col));
          check_field("square_row", longint'(out_o.square_row), longint'(want.square_row));
          check_field("wedge", longint'(out_o.wedge), longint'(want.wedge));
          check_field("glyph_code", longint'(out_o.glyph_code), longint'(want.glyph_code));
          check_field("edge_distance", longint'(out_o.edge_distance),
                      longint'(want.edge_distance));
          check_field("on_edge", longint'(out_o.on_edge), longint'(want.on_edge));
        end
        results_seen++;
      end
      if (start && !busy) expected_classes.push_back(classify_pixel(in_i));
    end
  end

  // Watchdog: too long without a pixel transfer or a result means a hang.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sends one pixel, then keeps the burst and gap pattern of the sender.
  task automatic send_pixel(input logic [SCREEN_BITS-1:0] col,
                            input logic [SCREEN_BITS-1:0] row);
    pix_in_t px;
    px.screen_col = col;
    px.screen_row = row;
    start <= 1'b1;
    in_i  <= px;
    do @(posedge clk_i); while (busy);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  // Stops sending and waits until the pipeline has emptied.
  task automatic drain_pixels();
    start <= 1'b0;
    while (expected_classes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_ORIGIN_X:     grid_org_x = data[SCREEN_BITS-1:0];
      REG_ORIGIN_Y:     grid_org_y = data[SCREEN_BITS-1:0];
      REG_CELL_WIDTH:   cell_w     = data[CELL_W-1:0];
      REG_CELL_HEIGHT:  cell_h     = data[CELL_W-1:0];
      REG_INVERSE_SIZE: inv_size   = data[INV_W-1:0];
      REG_BORDER_WIDTH: border_thr = data;
      default: ;
    endcase
  endtask

  // Writes the whole register file while the block is idle.
  task automatic set_registers(input int ox, input int oy, input int cw, input int ch,
                               input int inv, input int bw);
    drain_pixels();
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(REG_CELL_WIDTH, CFG_DATA_W'(cw));
    write_reg(REG_CELL_HEIGHT, CFG_DATA_W'(ch));
    write_reg(REG_INVERSE_SIZE, CFG_DATA_W'(inv));
    write_reg(REG_BORDER_WIDTH, CFG_DATA_W'(bw));
    cfg_we_i <= 1'b0;
  endtask

  // Corners of the screen under the reset register values.
  task automatic test_reset_defaults();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
  endtask

  // Square of 16 sub-pixels with one sub-pixel per cell: fractions land on
  // sixteenths, so wedge ties, side ties and the exact center all occur.
  task automatic test_exact_grid();
    set_registers(0, 0, 1, 1, 4096, 6554);
    send_pixel(10'd8, 10'd8);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd12, 10'd8);
    send_pixel(10'd4, 10'd8);
    send_pixel(10'd8, 10'd12);
    send_pixel(10'd8, 10'd4);
    send_pixel(10'd12, 10'd12);
    send_pixel(10'd4, 10'd12);
    send_pixel(10'd15, 10'd1);
    // Positions left of and above the origin give negative squares.
    set_registers(8, 8, 1, 1, 4096, 0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1, 10'd1023);
  endtask

  // A zero cell size or a zero reciprocal collapses every point to square 0.
  task automatic test_zero_scale();
    set_registers(100, 200, 0, 0, 3641, 6554);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd5, 10'd700);
    set_registers(100, 200, 15, 15, 0, 65536);
    send_pixel(10'd1023, 10'd0);
  endtask

  // Register values beyond their stated ranges push the square index past
  // twelve signed bits, where it wraps.
  task automatic test_index_wrap();
    set_registers(0, 0, 15, 15, 16383, 131071);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    set_registers(1023, 1023, 15, 15, 16383, 131071);
    send_pixel(10'd0, 10'd0);
  endtask

  // Writes to indexes that name no register must leave the settings alone.
  task automatic test_unknown_index();
    drain_pixels();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '0);
    cfg_we_i <= 1'b0;
    send_pixel(10'd511, 10'd512);
    send_pixel(10'd700, 10'd3);
  endtask

  // Random pixels under a run of settings, the extremes among them.
  task automatic test_random_phases();
    int ox, oy, cw, ch, inv, bw, col, row;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin ox = 0; oy = 0; cw = 1; ch = 1; inv = 1365; bw = 0; end
        1: begin ox = 1023; oy = 1023; cw = 15; ch = 15; inv = 8192; bw = 65536; end
        2: begin ox = 512; oy = 300; cw = 15; ch = 1; inv = 16383; bw = 131071; end
        default: begin
          ox  = $urandom_range(0, 1023);
          oy  = $urandom_range(0, 1023);
          cw  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 15);
          ch  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 15);
          inv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383)
                                            : $urandom_range(1365, 8192);
          bw  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                            : $urandom_range(0, 13107);
        end
      endcase
      set_registers(ox, oy, cw, ch, inv, bw);
      // Every third phase runs back to back with no gaps at all.
      gaps_on    = (ph % 3 != 1);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          // Near the origin the square index crosses zero.
          col = (ox + $urandom_range(0, 40) - 20) & 1023;
          row = (oy + $urandom_range(0, 40) - 20) & 1023;
        end else begin
          col = $urandom_range(0, 1023);
          row = $urandom_range(0, 1023);
        end
        send_pixel(col[SCREEN_BITS-1:0], row[SCREEN_BITS-1:0]);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_exact_grid();
    test_zero_scale();
    test_index_wrap();
    test_unknown_index();
    test_random_phases();

    // Let the last results out, then allow time for any stray one.
    start <= 1'b0;
    while (expected_classes.size() != 0) @(posedge clk_i);
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    if (expected_classes.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_classes.size()));
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
